### rtl/stepgen_pkg.sv
// shared field widths for the stepper step generator
package stepgen_pkg;
   localparam int ELAPSED_W = 16;
   localparam int SPEED_W   = 16;
   localparam int STEPS_W   = 32;
   localparam int MSPIN_W   = 3;
   localparam int COUNT_W   = 32;
endpackage

### rtl/stepgen_if.sv
// item channels of the stepper step generator

interface stepgen_req_if;
   import stepgen_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       update_now;
   logic [ELAPSED_W-1:0]       elapsed_ms;
   logic signed [SPEED_W-1:0]  speed_target;
   logic                       run_enable;
   logic signed [STEPS_W-1:0]  move_steps;
   logic                       trigger_level;
   modport source (output valid, update_now, elapsed_ms, speed_target, run_enable,
                   move_steps, trigger_level, input ready);
   modport sink (input valid, update_now, elapsed_ms, speed_target, run_enable,
                 move_steps, trigger_level, output ready);
endinterface

interface stepgen_rsp_if;
   import stepgen_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       step_out;
   logic                       dir_out;
   logic                       enable_n_out;
   logic [MSPIN_W-1:0]         microstep_pins;
   logic signed [SPEED_W-1:0]  present_speed;
   logic                       is_active;
   logic [STEPS_W-1:0]         steps_left;
   logic [COUNT_W-1:0]         total_steps;
   logic                       move_done;
   modport source (output valid, step_out, dir_out, enable_n_out, microstep_pins,
                   present_speed, is_active, steps_left, total_steps, move_done,
                   input ready);
   modport sink (input valid, step_out, dir_out, enable_n_out, microstep_pins,
                 present_speed, is_active, steps_left, total_steps, move_done,
                 output ready);
endinterface

### rtl/stepper_step_generator.sv
// stepper step/direction pulse generator top level
//
// usage:
//  req_if carries one item per timer tick; an item may carry a control update
//  (speed mode ramp or position move start). rsp_if returns one item per tick
//  with the step, direction and enable pin levels plus status.
//  csr_* is an apb-style register port (7 registers at byte address 4*i);
//  the user must write it only while the block is idle; the block does not enforce this.
// processing:
//  a tick without update goes from accept through the tick state to the result.
//  an update runs a bit-serial restoring divider, one quotient bit a cycle
//  over 40 bits: ramp step /1000, step rate /(60*2^frac), period = ticks/rate.
//  a speed update runs the divider up to three times (ramp, rate, period), a move start twice.
//  one item is in work at a time; the next is taken once the result is taken.
// reset: synchronous, clears registers to their defaults, motor stopped and
//  de-energized (enable_n high), no result pending.
// stall: while rsp_if.ready is low the result holds and no new item is taken.
module stepper_step_generator #(
   parameter int TICKS_PER_SECOND = 1000000,
   parameter int MIN_PERIOD       = 4,
   parameter int PULSE_TICKS      = 2,
   parameter int SPEED_FRAC_BITS  = 4
) (
   input  logic        clock,
   input  logic        reset,
   stepgen_req_if.sink   req_if,
   stepgen_rsp_if.source rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import stepgen_pkg::*;

   // divider geometry: dividend up to 36 bits, divisor up to 27 bits
   localparam int DW = 40;
   localparam int CW = 6;
   localparam logic [19:0] PERIOD_MAX = 20'hFFFFF;
   localparam logic [31:0] RATE_DEN   = 32'(60 << SPEED_FRAC_BITS);
   localparam logic [DW-1:0] TPS_DIV  = DW'(TICKS_PER_SECOND);
   localparam logic [19:0] MIN_P      = 20'(MIN_PERIOD);
   localparam logic [1:0]  PULSE_LD   = 2'(PULSE_TICKS);
   localparam int FAST_RAW = 300 << SPEED_FRAC_BITS;
   localparam int SLOW_RAW = 30 << SPEED_FRAC_BITS;
   localparam logic [14:0] DEF_FAST = (FAST_RAW > 32767) ? 15'd32767 : 15'(FAST_RAW);
   localparam logic [14:0] DEF_SLOW = (SLOW_RAW > 32767) ? 15'd32767 : 15'(SLOW_RAW);

   // register indexes
   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_ENABLE = 3'd1;
   localparam logic [2:0] REG_MAX    = 3'd2;
   localparam logic [2:0] REG_ACCEL  = 3'd3;
   localparam logic [2:0] REG_SPR    = 3'd4;
   localparam logic [2:0] REG_MSDIV  = 3'd5;
   localparam logic [2:0] REG_INV    = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPD, ST_RAMP, ST_DIR, ST_POS, ST_MUL1, ST_MUL2, ST_DIV, ST_FIN, ST_TICK
   } state_type;

   typedef enum logic [1:0] {DK_RAMP, DK_RATE, DK_PER} div_kind_type;

   // configuration
   logic        mode_ff, en_ff, inv_ff;
   logic [14:0] max_ff;
   logic [15:0] accel_ff, spr_ff;
   logic [4:0]  msdiv_ff;

   // latched item
   logic                      gate_ff, trig_ff;
   logic [ELAPSED_W-1:0]      elapsed_ff;
   logic signed [SPEED_W-1:0] target_ff;
   logic signed [STEPS_W-1:0] steps_ff;

   // motor state
   logic signed [SPEED_W-1:0] speed_ff;
   logic [19:0] period_ff, phase_ff;
   logic [1:0]  hold_ff;
   logic        running_ff, last_trig_ff, done_ff, dir_ff, en_n_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [STEPS_W-1:0] remain_ff;

   // working registers
   state_type    state_ff;
   div_kind_type kind_ff;
   logic [DW-1:0] prod_ff;
   logic [31:0]   den_ff, rem_ff, amt_ff;
   logic [CW-1:0] cnt_ff;
   logic signed [SPEED_W-1:0] tgt_ff;
   logic        up_ff;
   logic [15:0] pmag_ff;
   logic [STEPS_W-1:0] absn_ff;
   logic [19:0] p_ff;

   // result register
   logic                      rsp_valid_ff, step_r_ff, dir_r_ff, en_n_r_ff, act_r_ff, done_r_ff;
   logic [MSPIN_W-1:0]        ms_r_ff;
   logic signed [SPEED_W-1:0] speed_r_ff;
   logic [STEPS_W-1:0]        remain_r_ff;
   logic [COUNT_W-1:0]        count_r_ff;

   // effective configuration
   logic [15:0] spr_eff;
   logic [4:0]  div_eff;
   logic [MSPIN_W-1:0] ms_code;
   logic signed [SPEED_W-1:0] mx, tgt_clamp;
   logic [15:0] dt;

   assign spr_eff = (spr_ff != 16'd0) ? spr_ff : 16'd200;
   assign div_eff = (msdiv_ff != 5'd0) ? msdiv_ff : 5'd1;
   assign dt      = (elapsed_ff != 16'd0) ? elapsed_ff : 16'd1;
   assign mx      = {1'b0, ((max_ff != 15'd0) ? max_ff : DEF_FAST)};

   always_comb begin
      priority if (div_eff >= 5'd16) ms_code = 3'd7;
      else if (div_eff >= 5'd8) ms_code = 3'd3;
      else if (div_eff >= 5'd4) ms_code = 3'd2;
      else if (div_eff >= 5'd2) ms_code = 3'd1;
      else ms_code = 3'd0;
   end

   always_comb begin
      priority if (target_ff > mx) tgt_clamp = mx;
      else if (target_ff < -mx) tgt_clamp = -mx;
      else tgt_clamp = target_ff;
   end

   // ramp compare
   logic signed [16:0] diff;
   logic [16:0] magd;
   logic [26:0] magd_k;
   assign diff   = {tgt_ff[15], tgt_ff} - {speed_ff[15], speed_ff};
   assign magd   = diff[16] ? 17'(-diff) : 17'(diff);
   assign magd_k = 27'(magd) * 27'd1000;

   // speed magnitude and move length
   logic [15:0] smag;
   logic [STEPS_W-1:0] absn;
   assign smag = speed_ff[15] ? 16'(-speed_ff) : 16'(speed_ff);
   assign absn = steps_ff[31] ? (~steps_ff + 32'd1) : steps_ff;

   // one restoring divider step
   logic [32:0] rem_sh;
   logic        ge;
   logic [31:0] rem_in;
   logic [DW-1:0] quo_in;
   assign rem_sh = {rem_ff, prod_ff[DW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_in = ge ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
   assign quo_in = {prod_ff[DW-2:0], ge};

   // period clamp of the final quotient
   logic [19:0] p_clamp;
   always_comb begin
      priority if (quo_in < DW'(MIN_P)) p_clamp = MIN_P;
      else if (quo_in > DW'(PERIOD_MAX)) p_clamp = PERIOD_MAX;
      else p_clamp = quo_in[19:0];
   end

   // tick: phase advance and pulse stretch
   logic [19:0] phase_in;
   logic [STEPS_W-1:0] remain_in;
   logic [COUNT_W-1:0] count_in;
   logic fire;
   logic [1:0] hold_now, hold_in;
   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      fire      = 1'b0;
      if (running_ff && period_ff != 20'd0) begin
         phase_in = phase_ff + 20'd1;
         if (phase_in >= period_ff) begin
            phase_in = 20'd0;
            if (mode_ff) begin
               if (remain_ff != '0) begin
                  remain_in = remain_ff - 32'd1;
                  fire      = 1'b1;
               end
            end else begin
               count_in = count_ff + 32'd1;
               fire     = 1'b1;
            end
         end
      end
      hold_now = fire ? PULSE_LD : hold_ff;
      hold_in  = (hold_now != 2'd0) ? hold_now - 2'd1 : 2'd0;
   end

   // register port
   logic       csr_wr;
   logic [2:0] csr_idx;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_idx)
         REG_MODE:   csr_prdata = {31'd0, mode_ff};
         REG_ENABLE: csr_prdata = {31'd0, en_ff};
         REG_MAX:    csr_prdata = {17'd0, max_ff};
         REG_ACCEL:  csr_prdata = {16'd0, accel_ff};
         REG_SPR:    csr_prdata = {16'd0, spr_ff};
         REG_MSDIV:  csr_prdata = {27'd0, msdiv_ff};
         REG_INV:    csr_prdata = {31'd0, inv_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   logic accept;
   assign req_if.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept       = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; en_ff <= 1'b0; max_ff <= '0; accel_ff <= '0;
         spr_ff <= 16'd200; msdiv_ff <= 5'd1; inv_ff <= 1'b0;
         speed_ff <= '0; period_ff <= '0; phase_ff <= '0; hold_ff <= '0;
         running_ff <= 1'b0; count_ff <= '0; remain_ff <= '0;
         last_trig_ff <= 1'b0; done_ff <= 1'b0; dir_ff <= 1'b0; en_n_ff <= 1'b1;
         state_ff <= ST_IDLE; kind_ff <= DK_RAMP; rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready) rsp_valid_ff <= 1'b0;

         if (csr_wr) begin
            unique case (csr_idx)
               REG_MODE: begin
                  // a mode change stops the motor and clears the move
                  if (csr_pwdata[0] != mode_ff) begin
                     running_ff <= 1'b0; en_n_ff <= 1'b1; period_ff <= '0; phase_ff <= '0;
                     speed_ff <= '0; remain_ff <= '0;
                  end
                  mode_ff <= csr_pwdata[0];
               end
               REG_ENABLE: en_ff    <= csr_pwdata[0];
               REG_MAX:    max_ff   <= csr_pwdata[14:0];
               REG_ACCEL:  accel_ff <= csr_pwdata[15:0];
               REG_SPR:    spr_ff   <= csr_pwdata[15:0];
               REG_MSDIV:  msdiv_ff <= csr_pwdata[4:0];
               REG_INV:    inv_ff   <= csr_pwdata[0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  elapsed_ff <= req_if.elapsed_ms;
                  target_ff  <= req_if.speed_target;
                  gate_ff    <= req_if.run_enable;
                  steps_ff   <= req_if.move_steps;
                  trig_ff    <= req_if.trigger_level;
                  if (!req_if.update_now) state_ff <= ST_TICK;
                  else if (mode_ff) state_ff <= ST_POS;
                  else state_ff <= ST_SPD;
               end
            end
            ST_SPD: begin
               if (!en_ff || !gate_ff) begin
                  running_ff <= 1'b0; en_n_ff <= 1'b1; period_ff <= '0; phase_ff <= '0;
                  speed_ff <= '0;
                  state_ff <= ST_TICK;
               end else if (accel_ff != 16'd0) begin
                  tgt_ff   <= tgt_clamp;
                  amt_ff   <= 32'(accel_ff) * 32'(dt);
                  state_ff <= ST_RAMP;
               end else begin
                  speed_ff <= tgt_clamp;
                  state_ff <= ST_DIR;
               end
            end
            ST_RAMP: begin
               if (32'(magd_k) <= amt_ff) begin
                  speed_ff <= tgt_ff;
                  state_ff <= ST_DIR;
               end else begin
                  // ramp step = amount / 1000 toward the target
                  up_ff    <= !diff[16];
                  prod_ff  <= DW'(amt_ff);
                  den_ff   <= 32'd1000;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  kind_ff  <= DK_RAMP;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIR: begin
               dir_ff <= !speed_ff[15] ^ inv_ff;
               if (smag == 16'd0) begin
                  running_ff <= 1'b0; en_n_ff <= 1'b1; period_ff <= '0; phase_ff <= '0;
                  state_ff <= ST_TICK;
               end else begin
                  en_n_ff  <= 1'b0;
                  pmag_ff  <= smag;
                  state_ff <= ST_MUL1;
               end
            end
            ST_POS: begin
               last_trig_ff <= trig_ff;
               done_ff      <= 1'b0;
               state_ff     <= ST_TICK;
               if (!en_ff) begin
                  if (running_ff) begin
                     running_ff <= 1'b0; en_n_ff <= 1'b1; period_ff <= '0; phase_ff <= '0;
                     remain_ff <= '0;
                  end
               end else begin
                  if (running_ff && remain_ff == '0) begin
                     running_ff <= 1'b0; en_n_ff <= 1'b1; period_ff <= '0; phase_ff <= '0;
                     done_ff <= 1'b1;
                  end
                  // rising trigger with a nonzero step count and no move still running starts one
                  if (trig_ff && !last_trig_ff && steps_ff != '0 &&
                      !(running_ff && remain_ff != '0)) begin
                     absn_ff  <= absn;
                     dir_ff   <= !steps_ff[31] ^ inv_ff;
                     en_n_ff  <= 1'b0;
                     pmag_ff  <= {1'b0, ((max_ff != 15'd0) ? max_ff : DEF_SLOW)};
                     state_ff <= ST_MUL1;
                  end
               end
            end
            ST_MUL1: begin
               prod_ff  <= DW'(32'(pmag_ff) * 32'(spr_eff));
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               // step rate = speed * spr * div / (60 * 2^frac)
               prod_ff  <= DW'(prod_ff[31:0]) * DW'(div_eff);
               den_ff   <= RATE_DEN;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               kind_ff  <= DK_RATE;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff != CW'(DW - 1)) begin
                  prod_ff <= quo_in;
                  rem_ff  <= rem_in;
                  cnt_ff  <= cnt_ff + CW'(1);
               end else begin
                  unique case (kind_ff)
                     DK_RAMP: begin
                        speed_ff <= up_ff ? speed_ff + $signed(quo_in[15:0])
                                          : speed_ff - $signed(quo_in[15:0]);
                        state_ff <= ST_DIR;
                     end
                     DK_RATE: begin
                        if (quo_in == '0) begin
                           p_ff     <= '0;
                           state_ff <= ST_FIN;
                        end else begin
                           // period = ticks per second / step rate
                           prod_ff <= TPS_DIV;
                           den_ff  <= quo_in[31:0];
                           rem_ff  <= '0;
                           cnt_ff  <= '0;
                           kind_ff <= DK_PER;
                        end
                     end
                     DK_PER: begin
                        p_ff     <= p_clamp;
                        state_ff <= ST_FIN;
                     end
                     default: state_ff <= ST_FIN;
                  endcase
               end
            end
            ST_FIN: begin
               state_ff <= ST_TICK;
               if (p_ff == 20'd0) begin
                  if (!mode_ff) begin
                     running_ff <= 1'b0; en_n_ff <= 1'b1; period_ff <= '0; phase_ff <= '0;
                  end
               end else begin
                  if (mode_ff) begin
                     remain_ff <= absn_ff;
                     phase_ff  <= '0;
                  end else if (!running_ff) begin
                     phase_ff <= '0;
                  end
                  period_ff  <= p_ff;
                  running_ff <= 1'b1;
               end
            end
            ST_TICK: begin
               phase_ff     <= phase_in;
               remain_ff    <= remain_in;
               count_ff     <= count_in;
               hold_ff      <= hold_in;
               step_r_ff    <= hold_now != 2'd0;
               dir_r_ff     <= dir_ff;
               en_n_r_ff    <= en_n_ff;
               ms_r_ff      <= ms_code;
               speed_r_ff   <= speed_ff;
               act_r_ff     <= running_ff;
               remain_r_ff  <= remain_in;
               count_r_ff   <= count_in;
               done_r_ff    <= done_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.step_out       = step_r_ff;
   assign rsp_if.dir_out        = dir_r_ff;
   assign rsp_if.enable_n_out   = en_n_r_ff;
   assign rsp_if.microstep_pins = ms_r_ff;
   assign rsp_if.present_speed  = speed_r_ff;
   assign rsp_if.is_active      = act_r_ff;
   assign rsp_if.steps_left     = remain_r_ff;
   assign rsp_if.total_steps    = count_r_ff;
   assign rsp_if.move_done      = done_r_ff;

`ifndef ASSERT_OFF
   a_run_has_period: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> period_ff != 20'd0)
      else $error("running with zero period");
   a_remain_runs: assert property (@(posedge clock) disable iff (reset)
      remain_ff != '0 |-> running_ff)
      else $error("steps left while stopped");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item not in work");
`endif
endmodule
